// ===== rtl/bspe_pkg.sv =====
// Shared types, constants and basis-weight functions of the B-spline surface evaluator.
package bspe_pkg;

   localparam int GRID_AW  = 6;   // control index width per axis
   localparam int VERT_W   = 10;  // vertex index width
   localparam int HEIGHT_W = 16;  // Q8.8 height
   localparam int COORD_W  = 16;  // Q1.15 coordinate
   localparam int GSIZE_W  = 7;
   localparam int RES_W    = 5;
   localparam int WGT_W    = 15;  // basis weight scaled by 6*r^3
   localparam int DSQ_W    = 2 * WGT_W;
   localparam int ACC_W    = 48;  // accumulator and dividend width
   localparam int DEN_W    = 32;  // divisor width
   localparam int QUO_W    = 16;  // quotient bits per division
   localparam int CNT_W    = 5;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [GSIZE_W-1:0] GSIZE_MIN = 7'd4;
   localparam logic [GSIZE_W-1:0] GSIZE_MAX = 7'd64;
   localparam logic [RES_W-1:0]   RES_MIN   = 5'd1;
   localparam logic [RES_W-1:0]   RES_MAX   = 5'd16;

   localparam logic [1:0] CSR_GRID_X     = 2'd0;
   localparam logic [1:0] CSR_GRID_Z     = 2'd1;
   localparam logic [1:0] CSR_RESOLUTION = 2'd2;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_EVAL  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_PX,
      ST_DIV_PZ,
      ST_DIV_NX,
      ST_DIV_NZ,
      ST_WEIGHT,
      ST_MAC,
      ST_HLOAD,
      ST_HDIV,
      ST_FINISH
   } state_type;

   typedef logic [3:0][WGT_W-1:0] weight_set_type;

   function automatic logic [8:0] sq_tab(input logic [4:0] x);
      logic [8:0] v;
      case (x)
         5'd0:  v = 9'd0;
         5'd1:  v = 9'd1;
         5'd2:  v = 9'd4;
         5'd3:  v = 9'd9;
         5'd4:  v = 9'd16;
         5'd5:  v = 9'd25;
         5'd6:  v = 9'd36;
         5'd7:  v = 9'd49;
         5'd8:  v = 9'd64;
         5'd9:  v = 9'd81;
         5'd10: v = 9'd100;
         5'd11: v = 9'd121;
         5'd12: v = 9'd144;
         5'd13: v = 9'd169;
         5'd14: v = 9'd196;
         5'd15: v = 9'd225;
         5'd16: v = 9'd256;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   function automatic logic [12:0] cube_tab(input logic [4:0] x);
      logic [12:0] v;
      case (x)
         5'd0:  v = 13'd0;
         5'd1:  v = 13'd1;
         5'd2:  v = 13'd8;
         5'd3:  v = 13'd27;
         5'd4:  v = 13'd64;
         5'd5:  v = 13'd125;
         5'd6:  v = 13'd216;
         5'd7:  v = 13'd343;
         5'd8:  v = 13'd512;
         5'd9:  v = 13'd729;
         5'd10: v = 13'd1000;
         5'd11: v = 13'd1331;
         5'd12: v = 13'd1728;
         5'd13: v = 13'd2197;
         5'd14: v = 13'd2744;
         5'd15: v = 13'd3375;
         5'd16: v = 13'd4096;
         default: v = 13'd0;
      endcase
      return v;
   endfunction

   // Cubic B-spline weights for t = n/r, all scaled by 6*r^3 so they stay integers.
   function automatic weight_set_type basis_weights(input logic [3:0] n,
                                                    input logic [RES_W-1:0] r);
      logic [4:0]        n5;
      logic [4:0]        m;
      logic [13:0]       n2r_u;
      logic [13:0]       nr2_u;
      logic signed [17:0] n3;
      logic signed [17:0] r3;
      logic signed [17:0] n2r;
      logic signed [17:0] nr2;
      logic signed [17:0] w1;
      logic signed [17:0] w2;
      weight_set_type    w;
      n5    = {1'b0, n};
      m     = r - n5;
      n2r_u = {5'b0, sq_tab(n5)} * {9'b0, r};
      nr2_u = {10'b0, n} * {5'b0, sq_tab(r)};
      n3    = signed'({5'b0, cube_tab(n5)});
      r3    = signed'({5'b0, cube_tab(r)});
      n2r   = signed'({4'b0, n2r_u});
      nr2   = signed'({4'b0, nr2_u});
      w1    = 18'sd3 * n3 - 18'sd6 * n2r + 18'sd4 * r3;
      w2    = 18'sd3 * n2r + 18'sd3 * nr2 + r3 - 18'sd3 * n3;
      w[0]  = {2'b0, cube_tab(m)};
      w[1]  = w1[WGT_W-1:0];
      w[2]  = w2[WGT_W-1:0];
      w[3]  = {2'b0, cube_tab(n5)};
      return w;
   endfunction

endpackage

// ===== rtl/bspline_surface_point_evaluator.sv =====
// Uniform cubic B-spline height-field evaluator with a shared restoring divider and one MAC.
//
// Input words arrive on req_ (valid/ready). A write word (action 0) stores a Q8.8 control
// height at (ctrl_row, ctrl_col) of a 64x64 store; its result word (all zero, status 0)
// is ready in the cycle after acceptance. An evaluate word (action 1) names a surface
// vertex. An out-of-range vertex answers in the next cycle with status 1 and zero fields.
// A valid vertex runs two patch/parameter splits and two coordinate normalizations on the
// shared restoring divider, a weight step, memory reads into the MAC, a dividend load, the
// final rounded height division and a finish step that fills the output register; each
// division yields 16 quotient bits. With a ready receiver, writes and rejected vertices go
// at one word per cycle; a valid vertex holds off new words until it answers. Result words
// sit in an output register on rsp_; req_ready is high only when the sequencer is idle and
// that register is free or being emptied, so a stalled receiver holds off new words but no
// word is lost. Registers grid_size_x, grid_size_z and resolution sit at byte addresses 0,
// 4 and 8 of the csr_ port and must be written by the user only while the block is idle;
// the block itself does not enforce it. Synchronous reset returns the sequencer to idle,
// empties the output register and restores the register defaults; the control store is
// not cleared and must be written before it is read.
module bspline_surface_point_evaluator
   import bspe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_action,
   input  logic [GRID_AW-1:0]         req_ctrl_row,
   input  logic [GRID_AW-1:0]         req_ctrl_col,
   input  logic signed [HEIGHT_W-1:0] req_ctrl_height,
   input  logic [VERT_W-1:0]          req_vertex_x,
   input  logic [VERT_W-1:0]          req_vertex_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [HEIGHT_W-1:0] rsp_surface_height,
   output logic [COORD_W-1:0]         rsp_norm_x,
   output logic [COORD_W-1:0]         rsp_norm_z,
   output logic                       rsp_status,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   // Configuration registers
   logic [GSIZE_W-1:0] gx_ff, gx_in, gz_ff, gz_in;
   logic [RES_W-1:0]   res_ff, res_in;

   // Sequencer and datapath registers
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VERT_W-1:0]      vx_ff, vx_in, vz_ff, vz_in;
   logic [GRID_AW-1:0]     px_ff, px_in, pz_ff, pz_in;
   logic [3:0]             nx_ff, nx_in, nz_ff, nz_in;
   logic [COORD_W-1:0]     normx_ff, normx_in, normz_ff, normz_in;
   weight_set_type         wu_ff, wu_in, wv_ff, wv_in;
   logic [DSQ_W-1:0]       dsq_ff, dsq_in;
   logic [DSQ_W-1:0]       wprod_ff, wprod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]       div_num_ff, div_num_in;
   logic [DEN_W-1:0]       div_den_ff, div_den_in;
   logic [QUO_W-1:0]       div_quo_ff, div_quo_in;
   logic signed [HEIGHT_W-1:0] height_ff, height_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [HEIGHT_W-1:0] rsp_height_ff, rsp_height_in;
   logic [COORD_W-1:0]         rsp_nx_ff, rsp_nx_in, rsp_nz_ff, rsp_nz_in;
   logic                       rsp_status_ff, rsp_status_in;

   // Control store
   logic [HEIGHT_W-1:0]        grid_mem [0:(1 << (2 * GRID_AW)) - 1];
   logic signed [HEIGHT_W-1:0] rdata_ff;
   logic [2*GRID_AW-1:0]       rd_addr;

   logic [GSIZE_W-1:0] gx_c, gz_c;
   logic [RES_W-1:0]   res_c;
   logic [VERT_W-1:0]  cx, cz, cxm1, czm1;
   logic [10:0]        cx_full, cz_full;
   logic               out_free, req_fire, in_range, csr_wr;
   logic [ACC_W-1:0]   div_shift, div_rem_step;
   logic [QUO_W-1:0]   div_quo_step;
   logic               div_ge;
   logic [1:0]         mac_a, mac_b;
   logic signed [DSQ_W+HEIGHT_W:0] mac_prod;
   logic [WGT_W-1:0]   d_val;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      gx_in  = gx_ff;
      gz_in  = gz_ff;
      res_in = res_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_GRID_X:     gx_in  = csr_pwdata[GSIZE_W-1:0];
            CSR_GRID_Z:     gz_in  = csr_pwdata[GSIZE_W-1:0];
            CSR_RESOLUTION: res_in = csr_pwdata[RES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_GRID_X:     csr_prdata = {{(CSR_DW-GSIZE_W){1'b0}}, gx_ff};
         CSR_GRID_Z:     csr_prdata = {{(CSR_DW-GSIZE_W){1'b0}}, gz_ff};
         CSR_RESOLUTION: csr_prdata = {{(CSR_DW-RES_W){1'b0}}, res_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Registers saturate into their legal ranges before use.
   always_comb begin
      gx_c  = (gx_ff < GSIZE_MIN) ? GSIZE_MIN : ((gx_ff > GSIZE_MAX) ? GSIZE_MAX : gx_ff);
      gz_c  = (gz_ff < GSIZE_MIN) ? GSIZE_MIN : ((gz_ff > GSIZE_MAX) ? GSIZE_MAX : gz_ff);
      res_c = (res_ff < RES_MIN) ? RES_MIN : ((res_ff > RES_MAX) ? RES_MAX : res_ff);
      cx_full = {5'b0, gx_c[5:0] - 6'd3} * {6'b0, res_c};
      cz_full = {5'b0, gz_c[5:0] - 6'd3} * {6'b0, res_c};
      cx   = cx_full[VERT_W-1:0];
      cz   = cz_full[VERT_W-1:0];
      cxm1 = cx - 10'd1;
      czm1 = cz - 10'd1;
   end

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) & out_free;
   assign req_fire  = req_valid & req_ready;
   assign in_range  = (req_vertex_x < cx) & (req_vertex_z < cz);

   // One restoring step: the divisor is shifted to the quotient bit under work.
   always_comb begin
      div_shift    = {{(ACC_W-DEN_W){1'b0}}, div_den_ff} << cnt_ff[3:0];
      div_ge       = (div_num_ff >= div_shift);
      div_rem_step = div_ge ? (div_num_ff - div_shift) : div_num_ff;
      div_quo_step = div_quo_ff | ({{(QUO_W-1){1'b0}}, div_ge} << cnt_ff[3:0]);
   end

   assign mac_a   = cnt_ff[3:2];
   assign mac_b   = cnt_ff[1:0];
   assign rd_addr = {px_ff + {4'b0, mac_a}, pz_ff + {4'b0, mac_b}};
   assign mac_prod = $signed({1'b0, wprod_ff}) * rdata_ff;
   assign d_val   = ({2'b0, cube_tab(res_c)} << 2) + ({2'b0, cube_tab(res_c)} << 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire && req_action == ACTION_EVAL && in_range) state_in = ST_DIV_PX;
         ST_DIV_PX: if (cnt_ff == '0) state_in = ST_DIV_PZ;
         ST_DIV_PZ: if (cnt_ff == '0) state_in = ST_DIV_NX;
         ST_DIV_NX: if (cnt_ff == '0) state_in = ST_DIV_NZ;
         ST_DIV_NZ: if (cnt_ff == '0) state_in = ST_WEIGHT;
         ST_WEIGHT: state_in = ST_MAC;
         ST_MAC:    if (cnt_ff == 5'd16) state_in = ST_HLOAD;
         ST_HLOAD:  state_in = ST_HDIV;
         ST_HDIV:   if (cnt_ff == '0) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cnt_in        = cnt_ff;
      vx_in         = vx_ff;
      vz_in         = vz_ff;
      px_in         = px_ff;
      pz_in         = pz_ff;
      nx_in         = nx_ff;
      nz_in         = nz_ff;
      normx_in      = normx_ff;
      normz_in      = normz_ff;
      wu_in         = wu_ff;
      wv_in         = wv_ff;
      dsq_in        = dsq_ff;
      wprod_in      = wprod_ff;
      acc_in        = acc_ff;
      div_num_in    = div_num_ff;
      div_den_in    = div_den_ff;
      div_quo_in    = div_quo_ff;
      height_in     = height_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_height_in = rsp_height_ff;
      rsp_nx_in     = rsp_nx_ff;
      rsp_nz_in     = rsp_nz_ff;
      rsp_status_in = rsp_status_ff;

      if (state_ff != ST_IDLE && state_ff != ST_WEIGHT && state_ff != ST_MAC &&
          state_ff != ST_HLOAD && state_ff != ST_FINISH) begin
         div_num_in = div_rem_step;
         div_quo_in = div_quo_step;
         cnt_in     = cnt_ff - 5'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               vx_in = req_vertex_x;
               vz_in = req_vertex_z;
               if (req_action == ACTION_EVAL && in_range) begin
                  div_num_in = {{(ACC_W-VERT_W){1'b0}}, req_vertex_x};
                  div_den_in = {{(DEN_W-RES_W){1'b0}}, res_c};
                  div_quo_in = '0;
                  cnt_in     = 5'd15;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_height_in = '0;
                  rsp_nx_in     = '0;
                  rsp_nz_in     = '0;
                  rsp_status_in = (req_action == ACTION_EVAL);
               end
            end
         end
         ST_DIV_PX: begin
            if (cnt_ff == '0) begin
               px_in      = div_quo_step[GRID_AW-1:0];
               nx_in      = div_rem_step[3:0];
               div_num_in = {{(ACC_W-VERT_W){1'b0}}, vz_ff};
               div_quo_in = '0;
               cnt_in     = 5'd15;
            end
         end
         ST_DIV_PZ: begin
            if (cnt_ff == '0) begin
               pz_in      = div_quo_step[GRID_AW-1:0];
               nz_in      = div_rem_step[3:0];
               div_num_in = {{(ACC_W-VERT_W-16){1'b0}}, vx_ff, 16'b0} +
                            {{(ACC_W-VERT_W){1'b0}}, cxm1};
               div_den_in = {{(DEN_W-VERT_W-1){1'b0}}, cxm1, 1'b0};
               div_quo_in = '0;
               cnt_in     = 5'd15;
            end
         end
         ST_DIV_NX: begin
            if (cnt_ff == '0) begin
               // A single vertex along the axis gives coordinate zero.
               normx_in   = (cxm1 == '0) ? '0 : div_quo_step;
               div_num_in = {{(ACC_W-VERT_W-16){1'b0}}, vz_ff, 16'b0} +
                            {{(ACC_W-VERT_W){1'b0}}, czm1};
               div_den_in = {{(DEN_W-VERT_W-1){1'b0}}, czm1, 1'b0};
               div_quo_in = '0;
               cnt_in     = 5'd15;
            end
         end
         ST_DIV_NZ: begin
            if (cnt_ff == '0) begin
               normz_in = (czm1 == '0) ? '0 : div_quo_step;
            end
         end
         ST_WEIGHT: begin
            wu_in  = basis_weights(nx_ff, res_c);
            wv_in  = basis_weights(nz_ff, res_c);
            dsq_in = d_val * d_val;
            acc_in = '0;
            cnt_in = '0;
         end
         ST_MAC: begin
            // Reads and weight products are registered, so each is accumulated in the following cycle.
            wprod_in = wu_ff[mac_a] * wv_ff[mac_b];
            if (cnt_ff != '0) begin
               acc_in = acc_ff + {{(ACC_W-DSQ_W-HEIGHT_W-1){mac_prod[DSQ_W+HEIGHT_W]}},
                                  mac_prod};
            end
            cnt_in = cnt_ff + 5'd1;
         end
         ST_HLOAD: begin
            // Dividend 2S + D^2 plus an offset of 32768 quotients keeps it non-negative,
            // so a floor division by 2*D^2 rounds half up.
            div_num_in = {acc_ff[ACC_W-2:0], 1'b0} +
                         {{(ACC_W-DSQ_W-16){1'b0}}, dsq_ff, 16'b0} +
                         {{(ACC_W-DSQ_W){1'b0}}, dsq_ff};
            div_den_in = {{(DEN_W-DSQ_W-1){1'b0}}, dsq_ff, 1'b0};
            div_quo_in = '0;
            cnt_in     = 5'd15;
         end
         ST_HDIV: begin
            // The result is a convex mix of 16-bit heights, so it never leaves range.
            if (cnt_ff == '0) begin
               height_in = signed'({~div_quo_step[QUO_W-1], div_quo_step[QUO_W-2:0]});
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = height_ff;
               rsp_nx_in     = normx_ff;
               rsp_nz_in     = normz_ff;
               rsp_status_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gx_ff        <= GSIZE_MIN;
         gz_ff        <= GSIZE_MIN;
         res_ff       <= RES_MIN;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gx_ff        <= gx_in;
         gz_ff        <= gz_in;
         res_ff       <= res_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff         <= vx_in;
      vz_ff         <= vz_in;
      px_ff         <= px_in;
      pz_ff         <= pz_in;
      nx_ff         <= nx_in;
      nz_ff         <= nz_in;
      normx_ff      <= normx_in;
      normz_ff      <= normz_in;
      wu_ff         <= wu_in;
      wv_ff         <= wv_in;
      dsq_ff        <= dsq_in;
      wprod_ff      <= wprod_in;
      acc_ff        <= acc_in;
      div_num_ff    <= div_num_in;
      div_den_ff    <= div_den_in;
      div_quo_ff    <= div_quo_in;
      height_ff     <= height_in;
      rsp_height_ff <= rsp_height_in;
      rsp_nx_ff     <= rsp_nx_in;
      rsp_nz_ff     <= rsp_nz_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_action == ACTION_WRITE) begin
         grid_mem[{req_ctrl_row, req_ctrl_col}] <= req_ctrl_height;
      end
      rdata_ff <= grid_mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_surface_height = rsp_height_ff;
   assign rsp_norm_x         = rsp_nx_ff;
   assign rsp_norm_z         = rsp_nz_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the uniform cubic B-spline surface point evaluator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bspe_pkg::*;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;
   localparam int   ITEMS_PER_PHASE = 222;
   localparam int   STORE_DIM = 1 << GRID_AW;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_style_type;

   typedef struct {
      logic signed [HEIGHT_W-1:0] height;
      logic [COORD_W-1:0]         norm_x;
      logic [COORD_W-1:0]         norm_z;
      logic                       status;
   } surface_answer_type;

   // Mirrors the control store and registers, predicts each answer word and checks it.
   class surface_tracker;
      logic signed [HEIGHT_W-1:0] heights [STORE_DIM][STORE_DIM];
      logic [GSIZE_W-1:0]         reg_grid_x;
      logic [GSIZE_W-1:0]         reg_grid_z;
      logic [RES_W-1:0]           reg_res;
      surface_answer_type         pending_answers[$];
      int                         mismatches;

      function new();
         foreach (heights[i, j]) heights[i][j] = '0;
         reg_grid_x = GSIZE_MIN;
         reg_grid_z = GSIZE_MIN;
         reg_res    = RES_MIN;
         mismatches = 0;
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
         case (idx)
            CSR_GRID_X:     reg_grid_x = value[GSIZE_W-1:0];
            CSR_GRID_Z:     reg_grid_z = value[GSIZE_W-1:0];
            CSR_RESOLUTION: reg_res    = value[RES_W-1:0];
            default: ;
         endcase
      endfunction

      function int clamp_int(input int v, input int lo, input int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // Vertex counts along each axis and the resolution, after saturation.
      function void vertex_counts(output int cx, output int cz, output int r);
         r  = clamp_int(int'(reg_res), int'(RES_MIN), int'(RES_MAX));
         cx = (clamp_int(int'(reg_grid_x), int'(GSIZE_MIN), int'(GSIZE_MAX)) - 3) * r;
         cz = (clamp_int(int'(reg_grid_z), int'(GSIZE_MIN), int'(GSIZE_MAX)) - 3) * r;
      endfunction

      function longint floor_div(input longint n, input longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q = q - 1;
         return q;
      endfunction

      // Basis weight k for t = n/r, scaled by 6*r^3.
      function longint weight(input int k, input longint n, input longint r);
         longint m;
         m = r - n;
         case (k)
            0:       return m * m * m;
            1:       return 3 * n * n * n - 6 * n * n * r + 4 * r * r * r;
            2:       return -3 * n * n * n + 3 * n * n * r + 3 * n * r * r + r * r * r;
            default: return n * n * n;
         endcase
      endfunction

      function logic [COORD_W-1:0] norm_coord(input longint v, input longint count);
         longint q;
         if (count <= 1) return '0;
         q = (v * 65536 + count - 1) / (2 * (count - 1));
         return q[COORD_W-1:0];
      endfunction

      function void note_request(input logic action, input logic [GRID_AW-1:0] row,
                                 input logic [GRID_AW-1:0] col,
                                 input logic signed [HEIGHT_W-1:0] height,
                                 input logic [VERT_W-1:0] vx, input logic [VERT_W-1:0] vz);
         surface_answer_type ans;
         int                 cx, cz, r, px, pz, nu, nv;
         longint             acc, d, d2, h;
         ans.height = '0;
         ans.norm_x = '0;
         ans.norm_z = '0;
         ans.status = STATUS_OK;
         if (action == ACTION_WRITE) begin
            heights[row][col] = height;
         end else begin
            vertex_counts(cx, cz, r);
            if (int'(vx) >= cx || int'(vz) >= cz) begin
               ans.status = STATUS_RANGE;
            end else begin
               px  = int'(vx) / r;
               pz  = int'(vz) / r;
               nu  = int'(vx) % r;
               nv  = int'(vz) % r;
               acc = 0;
               for (int a = 0; a < 4; a++)
                  for (int b = 0; b < 4; b++)
                     acc += weight(a, nu, r) * weight(b, nv, r) *
                            longint'(heights[px + a][pz + b]);
               d  = 6 * r * r * r;
               d2 = d * d;
               // Round to nearest with halves toward positive infinity, then saturate.
               h = floor_div(2 * acc + d2, 2 * d2);
               if (h > 32767) h = 32767;
               if (h < -32768) h = -32768;
               ans.height = h[HEIGHT_W-1:0];
               ans.norm_x = norm_coord(longint'(vx), cx);
               ans.norm_z = norm_coord(longint'(vz), cz);
            end
         end
         pending_answers.push_back(ans);
      endfunction

      function void complain(input string what, input longint expv, input longint actv);
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, what, expv, actv);
      endfunction

      function void check_response(input logic signed [HEIGHT_W-1:0] height,
                                   input logic [COORD_W-1:0] nx,
                                   input logic [COORD_W-1:0] nz, input logic status);
         surface_answer_type want;
         if (pending_answers.size() == 0) begin
            complain("unrequested word, status", -1, longint'(status));
            return;
         end
         want = pending_answers.pop_front();
         if (height !== want.height)
            complain("surface_height", longint'(want.height), longint'(height));
         if (nx !== want.norm_x) complain("norm_x", longint'(want.norm_x), longint'(nx));
         if (nz !== want.norm_z) complain("norm_z", longint'(want.norm_z), longint'(nz));
         if (status !== want.status)
            complain("status", longint'(want.status), longint'(status));
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_action = ACTION_WRITE;
   logic [GRID_AW-1:0]         req_ctrl_row = '0;
   logic [GRID_AW-1:0]         req_ctrl_col = '0;
   logic signed [HEIGHT_W-1:0] req_ctrl_height = '0;
   logic [VERT_W-1:0]          req_vertex_x = '0;
   logic [VERT_W-1:0]          req_vertex_z = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [HEIGHT_W-1:0] rsp_surface_height;
   logic [COORD_W-1:0]         rsp_norm_x;
   logic [COORD_W-1:0]         rsp_norm_z;
   logic                       rsp_status;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]          csr_paddr = '0;
   logic [CSR_DW-1:0]          csr_pwdata = '0;
   logic [CSR_DW-1:0]          csr_prdata;
   logic                       csr_pready;

   surface_tracker tracker;
   idle_style_type idle_style = IDLE_NONE;
   bit             written [STORE_DIM][STORE_DIM];

   bspline_surface_point_evaluator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_request(req_action, req_ctrl_row, req_ctrl_col, req_ctrl_height,
                                 req_vertex_x, req_vertex_z);
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_surface_height, rsp_norm_x, rsp_norm_z, rsp_status);
      end
   end

   always @(posedge clock) begin
      case (idle_style)
         IDLE_RECV: rsp_ready <= ($urandom_range(99) >= 47);
         IDLE_BOTH: rsp_ready <= ($urandom_range(99) >= 12);
         default:   rsp_ready <= 1'b1;
      endcase
   end

   function automatic bit sender_idles();
      case (idle_style)
         IDLE_SEND: return $urandom_range(99) < 47;
         IDLE_BOTH: return $urandom_range(99) < 12;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic logic [HEIGHT_W-1:0] rand_height();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         default: return HEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic int pick_vertex(input int count);
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return 0;
      if (sel == 1) return count - 1;
      return $urandom_range(count - 1);
   endfunction

   task automatic send_word(input logic action, input logic [GRID_AW-1:0] row,
                            input logic [GRID_AW-1:0] col, input logic [HEIGHT_W-1:0] height,
                            input logic [VERT_W-1:0] vx, input logic [VERT_W-1:0] vz);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= action;
      req_ctrl_row    <= row;
      req_ctrl_col    <= col;
      req_ctrl_height <= height;
      req_vertex_x    <= vx;
      req_vertex_z    <= vz;
      do @(posedge clock); while (!req_ready);
      if (action == ACTION_WRITE) written[row][col] = 1'b1;
   endtask

   // Stop sending and wait until every answer word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_reg(idx, CSR_DW'(value));
   endtask

   task automatic configure(input int gx, input int gz, input int res);
      drain();
      csr_write(CSR_GRID_X, gx);
      csr_write(CSR_GRID_Z, gz);
      csr_write(CSR_RESOLUTION, res);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Reset defaults give a single-vertex surface, so both coordinates come out zero.
   task automatic directed_checks();
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            send_word(ACTION_WRITE, GRID_AW'(i), GRID_AW'(j), 16'h8000, 10'h3FF, 10'h3FF);
      send_word(ACTION_EVAL, 6'd63, 6'd63, 16'h7FFF, 10'd0, 10'd0);
      send_word(ACTION_EVAL, 6'd0, 6'd0, 16'h0000, 10'd1, 10'd0);
      send_word(ACTION_EVAL, 6'd0, 6'd0, 16'h0000, 10'd0, 10'h3FF);
      send_word(ACTION_WRITE, 6'd63, 6'd63, 16'h7FFF, 10'd0, 10'd0);
      send_word(ACTION_WRITE, 6'd63, 6'd0, 16'h0000, 10'd0, 10'd0);
      send_word(ACTION_WRITE, 6'd0, 6'd63, 16'hFFFF, 10'd0, 10'd0);
   endtask

   task automatic random_phase(input idle_style_type style);
      int sent, cx, cz, r, vx, vz, px, pz, sel;
      idle_style = style;
      sent = 0;
      tracker.vertex_counts(cx, cz, r);
      while (sent < ITEMS_PER_PHASE) begin
         sel = $urandom_range(99);
         if (sel < 15) begin
            send_word(ACTION_WRITE, GRID_AW'($urandom), GRID_AW'($urandom), rand_height(),
                      VERT_W'($urandom), VERT_W'($urandom));
            sent++;
         end else if (sel < 25) begin
            sel = $urandom_range(2);
            vx = ($urandom_range(3) == 0) ? cx : $urandom_range(1023, cx);
            vz = ($urandom_range(3) == 0) ? cz : $urandom_range(1023, cz);
            if (sel == 0) vz = $urandom_range(1023);
            if (sel == 1) vx = $urandom_range(1023);
            send_word(ACTION_EVAL, GRID_AW'($urandom), GRID_AW'($urandom),
                      HEIGHT_W'($urandom), VERT_W'(vx), VERT_W'(vz));
            sent++;
         end else begin
            vx = pick_vertex(cx);
            vz = pick_vertex(cz);
            px = vx / r;
            pz = vz / r;
            // Fill any part of the covering patch that has never been written.
            for (int a = 0; a < 4; a++)
               for (int b = 0; b < 4; b++)
                  if (!written[px + a][pz + b]) begin
                     send_word(ACTION_WRITE, GRID_AW'(px + a), GRID_AW'(pz + b), rand_height(),
                               VERT_W'($urandom), VERT_W'($urandom));
                     sent++;
                  end
            send_word(ACTION_EVAL, GRID_AW'($urandom), GRID_AW'($urandom),
                      HEIGHT_W'($urandom), VERT_W'(vx), VERT_W'(vz));
            sent++;
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      directed_checks();
      random_phase(IDLE_NONE);
      configure(64, 64, 16);
      random_phase(IDLE_SEND);
      // Out-of-range register values saturate into the legal ranges.
      configure(0, 127, 0);
      random_phase(IDLE_RECV);
      configure(127, 5, 31);
      random_phase(IDLE_BOTH);
      configure(7, 9, 3);
      random_phase(IDLE_NONE);
      configure($urandom_range(64, 4), $urandom_range(64, 4), $urandom_range(16, 1));
      random_phase(IDLE_SEND);
      configure(64, 64, 1);
      random_phase(IDLE_RECV);
      configure(5, 4, 16);
      random_phase(IDLE_BOTH);
      configure($urandom_range(127), $urandom_range(127), $urandom_range(31));
      random_phase(IDLE_NONE);
      drain();
      repeat (200) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
